/* sv/kws_pkg.sv */
// Package for the k-mer window shifter: the command that the front end
// hands to the execution back end, and the ASCII codes the front end decodes.
// No dependencies.
package kws_pkg;

	localparam int MaxBases = 4;

	// One classified input transaction: up to four bases in stream order.
	typedef struct packed {
		logic                     start;     // clear window, mask and position first
		logic [2:0]               nb;        // number of bases, 0 to 4
		logic [MaxBases-1:0][1:0] codes;     // codes[i] is base i
		logic [MaxBases-1:0]      unk;       // unk[i] marks base i unknown
		logic [1:0]               last_idx;  // index of the last known base
		logic [15:0]              tag;
	} cmd_t;

	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChNU    = 8'h4E;
	localparam logic [7:0] ChNL    = 8'h6E;
	localparam logic [7:0] ChCU    = 8'h43;
	localparam logic [7:0] ChCL    = 8'h63;
	localparam logic [7:0] ChAU    = 8'h41;
	localparam logic [7:0] ChAL    = 8'h61;
	localparam logic [7:0] ChGU    = 8'h47;
	localparam logic [7:0] ChGL    = 8'h67;

	localparam logic [1:0] CodeT = 2'd0;
	localparam logic [1:0] CodeC = 2'd1;
	localparam logic [1:0] CodeA = 2'd2;
	localparam logic [1:0] CodeG = 2'd3;

	localparam logic ModePacked = 1'b0;

endpackage

/* sv/kws_if.sv */
// Valid/ready channel interfaces for the k-mer window shifter: base input
// and window result. No dependencies.
interface kws_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [7:0]  data;
	logic [3:0]  unknown_mask;
	logic [2:0]  base_count;
	logic        sequence_start;
	logic [15:0] sequence_id;

	modport source(output valid, mode, data, unknown_mask, base_count, sequence_start,
		sequence_id, input ready);
	modport sink(input valid, mode, data, unknown_mask, base_count, sequence_start,
		sequence_id, output ready);
endinterface

interface kws_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] window;
	logic [63:0] valid_bits;
	logic [31:0] position;
	logic [15:0] sequence_tag;
	logic        last_of_item;

	modport source(output valid, window, valid_bits, position, sequence_tag, last_of_item,
		input ready);
	modport sink(input valid, window, valid_bits, position, sequence_tag, last_of_item,
		output ready);
endinterface

/* sv/kws_front.sv */
// Front end: accepts input transactions and classifies them into commands.
// Depends on kws_pkg and kws_in_if.
module kws_front (
	kws_in_if.sink        bases,
	input  logic          q_full,
	output logic          q_wr,
	output kws_pkg::cmd_t q_cmd
);
	import kws_pkg::*;

	logic [2:0] nb_sat;
	logic [1:0] lcode;
	logic       lskip;
	logic       lunk;

	assign bases.ready = !q_full;
	assign q_wr = bases.valid && !q_full;
	assign nb_sat = (bases.base_count > 3'd4) ? 3'd4 : bases.base_count;

	always_comb begin
		lskip = 1'b0;
		lunk = 1'b0;
		lcode = CodeT;
		case (bases.data)
			ChSpace, ChTab, ChCr, ChLf: lskip = 1'b1;
			ChNU, ChNL: lunk = 1'b1;
			ChCU, ChCL: lcode = CodeC;
			ChAU, ChAL: lcode = CodeA;
			ChGU, ChGL: lcode = CodeG;
			default: lcode = CodeT;
		endcase
	end

	always_comb begin
		q_cmd.start = bases.sequence_start;
		q_cmd.tag = bases.sequence_id;
		q_cmd.codes = '0;
		q_cmd.unk = '0;
		q_cmd.last_idx = 2'd0;
		if (bases.mode == ModePacked) begin
			q_cmd.nb = nb_sat;
			for (int i = 0; i < MaxBases; i++) begin
				q_cmd.codes[i] = bases.data[7-2*i -: 2];
				q_cmd.unk[i] = bases.unknown_mask[3-i];
				// The last known base among those used carries the end-of-item flag.
				if (3'(i) < nb_sat && !bases.unknown_mask[3-i])
					q_cmd.last_idx = 2'(i);
			end
		end else begin
			q_cmd.nb = lskip ? 3'd0 : 3'd1;
			q_cmd.codes[0] = lcode;
			q_cmd.unk[0] = lunk;
		end
	end

endmodule

/* sv/kws_queue.sv */
// Two-entry command queue between the front and back ends.
// Depends on kws_pkg.
module kws_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  kws_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd,
	output logic          head_valid,
	output kws_pkg::cmd_t head
);
	import kws_pkg::*;

	cmd_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr)
				wptr_q <= !wptr_q;
			if (rd)
				rptr_q <= !rptr_q;
			if (wr && !rd)
				cnt_q <= cnt_q + 2'd1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

/* sv/kws_back.sv */
// Back end: executes queued commands one base per cycle while its result
// register is free, keeps the window, fill mask and position, and drives
// the registered result channel. Depends on kws_pkg and kws_out_if.
module kws_back #(
	parameter int WINDOW_BASES = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  kws_pkg::cmd_t head,
	output logic          rd,
	kws_out_if.source     results
);
	import kws_pkg::*;

	localparam logic [63:0] KeepMask = ~({64{1'b1}} >> (2 * WINDOW_BASES));

	logic [63:0] win_q;
	logic [63:0] mask_q;
	logic [31:0] pos_q;
	logic [1:0]  idx_q;

	logic        ovalid_q;
	logic [63:0] owin_q;
	logic [63:0] omask_q;
	logic [31:0] opos_q;
	logic [15:0] otag_q;
	logic        olast_q;

	logic        clr;
	logic [63:0] bwin;
	logic [63:0] bmask;
	logic [31:0] bpos;
	logic        is_unk;
	logic [1:0]  code;
	logic        empty_cmd;
	logic        last_slot;
	logic        out_free;
	logic        fire;
	logic        emit;
	logic [63:0] nwin;
	logic [63:0] nmask;
	logic [31:0] npos;

	// A sequence start takes effect before the first base of its command.
	assign clr = (idx_q == 2'd0) && head.start;
	assign bwin = clr ? '0 : win_q;
	assign bmask = clr ? '0 : mask_q;
	assign bpos = clr ? '0 : pos_q;
	assign is_unk = head.unk[idx_q];
	assign code = head.codes[idx_q];
	assign empty_cmd = (head.nb == 3'd0);
	assign last_slot = ({1'b0, idx_q} == head.nb - 3'd1);
	assign out_free = !ovalid_q || results.ready;
	assign emit = !empty_cmd && !is_unk;
	assign fire = head_valid && (!emit || out_free);
	assign rd = fire && (empty_cmd || last_slot);

	always_comb begin
		if (empty_cmd) begin
			nwin = bwin;
			nmask = bmask;
			npos = bpos;
		end else if (is_unk) begin
			nwin = '0;
			nmask = '0;
			npos = bpos + 32'd1;
		end else begin
			nwin = ((bwin >> 2) | {code, 62'd0}) & KeepMask;
			nmask = ((bmask >> 2) | {2'b11, 62'd0}) & KeepMask;
			npos = bpos + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			mask_q <= '0;
			pos_q <= '0;
			idx_q <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (fire) begin
				win_q <= nwin;
				mask_q <= nmask;
				pos_q <= npos;
				idx_q <= rd ? 2'd0 : idx_q + 2'd1;
			end
			if (fire && emit)
				ovalid_q <= 1'b1;
			else if (results.ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			owin_q <= nwin;
			omask_q <= nmask;
			opos_q <= npos;
			otag_q <= head.tag;
			olast_q <= (idx_q == head.last_idx);
		end
	end

	assign results.valid = ovalid_q;
	assign results.window = owin_q;
	assign results.valid_bits = omask_q;
	assign results.position = opos_q;
	assign results.sequence_tag = otag_q;
	assign results.last_of_item = olast_q;

endmodule

/* sv/kmer_window_shifter_top.sv */
// Top level of the k-mer window shifter: front end, command queue, back end.
// Depends on kws_pkg, kws_if, kws_front, kws_queue and kws_back.
//
// Streams DNA bases into a sliding window of WINDOW_BASES 2-bit bases, newest in
// bits 63:62, and returns one result transaction per known base with the window,
// its fill mask, the 1-based position and the sequence tag. The front end takes
// one input transaction per cycle into a two-entry queue while it is not full;
// the back end, with a single base-shift step and a one-result output register,
// executes one base per cycle while that register can pass on its result. An
// item with no bases, such as a whitespace character, still passes through the
// back end as an empty command. Unknown bases and whitespace produce no result.
module kmer_window_shifter_top #(
	parameter int WINDOW_BASES = 32
) (
	input logic        clk,
	input logic        arst_n,
	kws_in_if.sink     bases,
	kws_out_if.source  results
);
	import kws_pkg::*;

	logic q_full;
	logic q_wr;
	cmd_t q_cmd;
	logic q_rd;
	logic head_valid;
	cmd_t head;

	kws_front u_front (
		.bases  (bases),
		.q_full (q_full),
		.q_wr   (q_wr),
		.q_cmd  (q_cmd)
	);

	kws_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (q_wr),
		.wr_cmd     (q_cmd),
		.full       (q_full),
		.rd         (q_rd),
		.head_valid (head_valid),
		.head       (head)
	);

	kws_back #(
		.WINDOW_BASES(WINDOW_BASES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.rd         (q_rd),
		.results    (results)
	);

endmodule

/* sv/kws_checker.sv */
// Port-level checker for the k-mer window shifter, bound to the top level.
// Depends on kmer_window_shifter_top.
module kws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [63:0] window,
	input logic [63:0] valid_bits,
	input logic [31:0] position
);

	// A stalled result transaction stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result transaction dropped while stalled");

	// A stalled result transaction keeps its payload.
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(window) && $stable(valid_bits) && $stable(position))
		else $error("result payload changed while stalled");

	// Every result has just taken in a base, so the newest slot is filled.
	a_newest: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> valid_bits[63:62] == 2'b11)
		else $error("newest window slot not marked filled");

	// Unfilled slots of the window read as zero.
	a_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (window & ~valid_bits) == 64'd0)
		else $error("window holds bits outside the fill mask");

	// The fill mask is one unbroken run of ones from the top.
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> ((valid_bits << 1) & ~valid_bits) == 64'd0)
		else $error("fill mask has a gap");

endmodule

bind kmer_window_shifter_top kws_checker u_kws_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (results.valid),
	.ready      (results.ready),
	.window     (results.window),
	.valid_bits (results.valid_bits),
	.position   (results.position)
);
